### hdl/pba_pkg.sv
// Shared types and codes for the page bitmap allocator.
package pba_pkg;

    // Operation codes of one request.
    typedef enum logic [1:0]
    {
        OP_ALLOC   = 2'd0,
        OP_FREE    = 2'd1,
        OP_ADD     = 2'd2,
        OP_RESERVE = 2'd3
    } op_t;

    // Request payload.
    typedef struct packed
    {
        op_t         op;
        logic [63:0] addr;
        logic [63:0] length;
    } req_t;

    // Response payload.
    typedef struct packed
    {
        logic [28:0] page_addr;
        logic        out_of_memory;
        logic [17:0] free_pages;
        logic [63:0] total_bytes;
    } rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed
    {
        logic capture;
        logic setup;
        logic range;
        logic eval;
        logic enc;
        logic clr;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed
    {
        logic empty;
        logic alloc;
        logic found;
        logic last_word;
        logic clr_last;
    } sts_t;

endpackage

### hdl/pba_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2048
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hdl/pba_ctrl.sv
// Controller state machine of the page bitmap allocator.
module pba_ctrl
    import pba_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  sts_t sts,
    output cmd_t cmd,
    output logic busy,
    output logic done
);

    typedef enum logic [7:0]
    {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_SETUP = 8'b0000_0100,
        S_RANGE = 8'b0000_1000,
        S_READ  = 8'b0001_0000,
        S_EVAL  = 8'b0010_0000,
        S_ENC   = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // State register; reset starts the clearing pass over the map.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_SETUP;
                end
            end
            S_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = S_RANGE;
            end
            S_RANGE:
            begin
                cmd.range  = 1'b1;
                state_next = sts.empty ? S_DONE : S_READ;
            end
            S_READ:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                cmd.eval = 1'b1;
                priority if (sts.alloc && sts.found)
                begin
                    state_next = S_ENC;
                end
                else if (sts.last_word)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_ENC:
            begin
                cmd.enc    = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

endmodule

### hdl/pba_dp.sv
// Datapath of the page bitmap allocator: map RAM, range setup and word update.
module pba_dp
    import pba_pkg::*;
#(
    parameter int NUM_PAGES  = 131072,
    parameter int PAGE_BYTES = 4096
) (
    input  logic clk,
    input  logic rst_n,
    input  req_t req,
    input  cmd_t cmd,
    output sts_t sts,
    output rsp_t rsp
);

    localparam int WORDS   = NUM_PAGES / 64;
    localparam int WADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int PW      = WADDR_W + 6;
    localparam int BW      = $clog2(NUM_PAGES + 1);
    localparam int SH      = $clog2(PAGE_BYTES);
    localparam logic [63:0] NP64    = 64'(NUM_PAGES);
    localparam logic [63:0] PB_MASK = 64'(PAGE_BYTES - 1);

    // Count of set bits as a tree of narrow adds.
    function automatic logic [6:0] popcnt(input logic [63:0] v);
        logic [1:0] l1 [32];
        logic [2:0] l2 [16];
        logic [3:0] l3 [8];
        logic [4:0] l4 [4];
        logic [5:0] l5 [2];
        for (int i = 0; i < 32; i++)
        begin
            l1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
        end
        for (int i = 0; i < 16; i++)
        begin
            l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
        end
        for (int i = 0; i < 8; i++)
        begin
            l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
        end
        for (int i = 0; i < 4; i++)
        begin
            l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
        end
        for (int i = 0; i < 2; i++)
        begin
            l5[i] = {1'b0, l4[2*i]} + {1'b0, l4[2*i+1]};
        end
        return {1'b0, l5[0]} + {1'b0, l5[1]};
    endfunction

    op_t               op_reg;
    logic [63:0]       addr_reg;
    logic [63:0]       len_reg;
    logic [63:0]       end_reg;
    logic [PW-1:0]     f_reg;
    logic [PW-1:0]     l_reg;
    logic [63:0]       word_reg;
    logic [63:0]       iso_reg;
    logic [28:0]       res_addr_reg;
    logic              oom_reg;
    logic [WADDR_W-1:0] w_reg;
    logic [WADDR_W-1:0] w_next;
    logic [17:0]       free_reg;
    logic [17:0]       free_next;
    logic [BW-1:0]     bound_reg;
    logic [BW-1:0]     bound_next;
    logic [63:0]       bytes_reg;
    logic [63:0]       bytes_next;

    logic [63:0]       rdata;
    logic [63:0]       wdata;
    logic              we;

    // Map RAM, one bit per page, set means used.
    pba_ram #(
        .WIDTH(64),
        .DEPTH(WORDS)
    ) u_map (
        .clk  (clk),
        .we   (we),
        .waddr(w_reg),
        .wdata(wdata),
        .raddr(w_reg),
        .rdata(rdata)
    );

    // Region end with saturation on overflow.
    logic [64:0] sum65;
    logic [63:0] end_sat;
    assign sum65   = {1'b0, addr_reg} + {1'b0, len_reg};
    assign end_sat = sum65[64] ? {64{1'b1}} : sum65[63:0];

    // Page range of the current operation.
    logic [63:0] sh_addr;
    logic [63:0] ps64;
    logic [63:0] pe64;
    logic [63:0] pe_cl;
    logic [63:0] bound64;
    logic [63:0] rng_f;
    logic [63:0] rng_l;
    logic        rng_empty;

    assign sh_addr = addr_reg >> SH;
    assign ps64    = sh_addr + 64'(|(addr_reg & PB_MASK));
    assign pe64    = end_reg >> SH;
    assign pe_cl   = (pe64 > NP64) ? NP64 : pe64;
    assign bound64 = 64'(bound_reg);

    always_comb
    begin
        unique case (op_reg)
            OP_ALLOC:
            begin
                rng_f     = '0;
                rng_l     = bound64 - 64'd1;
                rng_empty = (bound_reg == '0);
            end
            OP_FREE:
            begin
                rng_f     = sh_addr;
                rng_l     = sh_addr;
                rng_empty = (sh_addr >= NP64);
            end
            OP_ADD:
            begin
                rng_f     = ps64;
                rng_l     = pe_cl - 64'd1;
                rng_empty = (ps64 >= pe_cl);
            end
            OP_RESERVE:
            begin
                rng_f     = '0;
                rng_l     = (sh_addr > NP64 - 64'd1) ? NP64 - 64'd1 : sh_addr;
                rng_empty = 1'b0;
            end
            default:
            begin
                rng_f     = '0;
                rng_l     = '0;
                rng_empty = 1'b1;
            end
        endcase
    end

    // Mask of the range bits inside the current word.
    logic [5:0]  fbit;
    logic [5:0]  lbit;
    logic [63:0] mask;
    logic [63:0] cand;
    logic [63:0] iso;
    logic [63:0] eval_wdata;
    logic [6:0]  eval_cnt;

    assign fbit = (w_reg == f_reg[PW-1:6]) ? f_reg[5:0] : 6'd0;
    assign lbit = (w_reg == l_reg[PW-1:6]) ? l_reg[5:0] : 6'd63;
    assign mask = ({64{1'b1}} << fbit) & ({64{1'b1}} >> (6'd63 - lbit));
    assign cand = ~rdata & mask;
    assign iso  = cand & (~cand + 64'd1);

    // Word update for free, add region and reserve.
    always_comb
    begin
        if (op_reg == OP_RESERVE)
        begin
            eval_wdata = rdata | mask;
            eval_cnt   = popcnt(cand);
        end
        else
        begin
            eval_wdata = rdata & ~mask;
            eval_cnt   = popcnt(rdata & mask);
        end
    end

    // Index of the isolated free bit.
    logic [5:0]  idx;
    logic [PW-1:0] page;
    logic [63:0] page_bytes;

    always_comb
    begin
        idx = '0;
        for (int i = 0; i < 64; i++)
        begin
            idx = idx | (iso_reg[i] ? 6'(i) : 6'd0);
        end
    end

    assign page       = {w_reg, idx};
    assign page_bytes = 64'(page) << SH;

    // RAM write selection.
    always_comb
    begin
        we    = cmd.clr || (cmd.eval && (op_reg != OP_ALLOC)) || cmd.enc;
        wdata = {64{1'b1}};
        priority if (cmd.eval)
        begin
            wdata = eval_wdata;
        end
        else if (cmd.enc)
        begin
            wdata = word_reg | iso_reg;
        end
        else
        begin
            wdata = {64{1'b1}};
        end
    end

    // Next values of the counters and totals.
    always_comb
    begin
        w_next     = w_reg;
        free_next  = free_reg;
        bound_next = bound_reg;
        bytes_next = bytes_reg;
        if (cmd.clr)
        begin
            w_next = sts.clr_last ? '0 : w_reg + 1'b1;
        end
        if (cmd.setup && (op_reg == OP_ADD))
        begin
            bytes_next = bytes_reg + len_reg;
        end
        if (cmd.range)
        begin
            w_next = rng_f[PW-1:6];
            if ((op_reg == OP_ADD) && (pe_cl > bound64))
            begin
                bound_next = BW'(pe_cl);
            end
        end
        if (cmd.eval)
        begin
            if (op_reg == OP_ALLOC)
            begin
                if (cand == '0)
                begin
                    w_next = w_reg + 1'b1;
                end
            end
            else
            begin
                w_next = w_reg + 1'b1;
                if (op_reg == OP_RESERVE)
                begin
                    free_next = free_reg - 18'(eval_cnt);
                end
                else
                begin
                    free_next = free_reg + 18'(eval_cnt);
                end
            end
        end
        if (cmd.enc)
        begin
            free_next = free_reg - 18'd1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg     <= '0;
            free_reg  <= '0;
            bound_reg <= '0;
            bytes_reg <= '0;
        end
        else
        begin
            w_reg     <= w_next;
            free_reg  <= free_next;
            bound_reg <= bound_next;
            bytes_reg <= bytes_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= req.op;
            addr_reg <= req.addr;
            len_reg  <= req.length;
        end
        if (cmd.setup)
        begin
            end_reg <= end_sat;
        end
        if (cmd.range)
        begin
            f_reg        <= rng_f[PW-1:0];
            l_reg        <= rng_l[PW-1:0];
            res_addr_reg <= '0;
            oom_reg      <= (op_reg == OP_ALLOC);
        end
        if (cmd.eval)
        begin
            word_reg <= rdata;
            iso_reg  <= iso;
        end
        if (cmd.enc)
        begin
            res_addr_reg <= page_bytes[28:0];
            oom_reg      <= 1'b0;
        end
    end

    assign sts.empty     = rng_empty;
    assign sts.alloc     = (op_reg == OP_ALLOC);
    assign sts.found     = (cand != '0);
    assign sts.last_word = (w_reg == l_reg[PW-1:6]);
    assign sts.clr_last  = (w_reg == WADDR_W'(WORDS - 1));

    assign rsp.page_addr     = res_addr_reg;
    assign rsp.out_of_memory = oom_reg;
    assign rsp.free_pages    = free_reg;
    assign rsp.total_bytes   = bytes_reg;

endmodule

### hdl/page_bitmap_allocator.sv
// Sequence: setup and range steps, then a read and an evaluation of each map word
// in the range, up to the first word with a free page for an allocation (plus an encode
// step when it succeeds); an empty range, such as a free beyond the map, goes to done.
// Only one transaction runs at a time; the map RAM read and write-back per word set the pace.
// Reset: asynchronous, active low; afterwards a clearing pass over all NUM_PAGES/64 words
// marks every page used, with busy high. The result strobe lasts one cycle.
module page_bitmap_allocator
    import pba_pkg::*;
#(
    parameter int NUM_PAGES  = 131072,
    parameter int PAGE_BYTES = 4096
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  req_t req,
    output logic busy,
    output logic done,
    output rsp_t rsp
);

    cmd_t cmd;
    sts_t sts;

    // Controller.
    pba_ctrl u_ctrl (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .sts  (sts),
        .cmd  (cmd),
        .busy (busy),
        .done (done)
    );

    // Datapath.
    pba_dp #(
        .NUM_PAGES (NUM_PAGES),
        .PAGE_BYTES(PAGE_BYTES)
    ) u_dp (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req),
        .cmd  (cmd),
        .sts  (sts),
        .rsp  (rsp)
    );

    // An accepted transaction keeps the block busy.
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted transaction");

    // The result strobe lasts one cycle.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    // Out of memory always reports address zero.
    a_oom_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.out_of_memory) |-> (rsp.page_addr == '0))
        else $error("nonzero page address with out of memory");

    // Done is only raised while busy.
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done while idle");

endmodule
